// ===== hw/rtl/stereo_mixer_dc_high_pass_core_assert.svh =====
// assertion macros shared by the stereo mixer rtl
`ifndef STEREO_MIXER_DC_HIGH_PASS_CORE_ASSERT_SVH
`define STEREO_MIXER_DC_HIGH_PASS_CORE_ASSERT_SVH

// same-cycle implication
`define SMX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smx assertion failed");

// next-cycle implication
`define SMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smx assertion failed");

`endif

// ===== hw/rtl/smx_pkg.sv =====
// shared widths, constants and types of the stereo mixer
`timescale 1ns / 1ps
package smx_pkg;

    localparam int SAMPLE_FRAC_BITS = 13;
    localparam int CAP_FRAC_BITS    = 24;
    localparam int COEF_BITS        = 24;

    localparam int CH_N       = 4;
    localparam int SAMPLE_W   = 15;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int IN_SHIFT   = CAP_FRAC_BITS - SAMPLE_FRAC_BITS;
    localparam int IN_W       = SUM_W + IN_SHIFT;
    localparam int CAP_W      = 40;
    localparam int OUT_W      = 16;
    localparam int VOL_W      = 3;
    localparam int MASK_W     = 8;

    localparam int FULL_SCALE_LOG2 = 15;
    localparam int GAIN_W          = FULL_SCALE_LOG2 + VOL_W;
    localparam int SCALE_SHIFT     = CAP_FRAC_BITS + 5;
    localparam int MUL_LO_W        = (SCALE_SHIFT > COEF_BITS) ? SCALE_SHIFT : COEF_BITS;
    localparam int CNT_W           = $clog2(MUL_LO_W);

    localparam int OUT_POS_MAX = 32767;
    localparam int OUT_NEG_MAX = 32768;

    localparam logic [COEF_BITS-1:0] COEF_RESET = COEF_BITS'(16776511);

    typedef struct packed {
        logic                 start;
        logic [COEF_BITS-1:0] coef;
        logic [VOL_W-1:0]     vol;
    } t_hpf_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_hpf_stat;

endpackage

// ===== hw/rtl/smx_hpf.sv =====
// one side: dc-blocking high-pass and volume scaling on a bit-serial multiplier
`timescale 1ns / 1ps
module smx_hpf (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  smx_pkg::t_hpf_ctrl                 i_ctrl,
    input  logic signed [smx_pkg::SUM_W-1:0]   i_sum,
    output smx_pkg::t_hpf_stat                 o_stat,
    output logic signed [smx_pkg::OUT_W-1:0]   o_result
);
    import smx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_PREP,
        S_MUL1,
        S_CAP,
        S_MUL2,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic signed [CAP_W-1:0]   r_cap;
    logic signed [IN_W-1:0]    r_in;
    logic signed [CAP_W-1:0]   r_out;
    logic [CAP_W-1:0]          r_mag;
    logic                      r_neg;
    logic [CAP_W:0]            r_hi;
    logic [MUL_LO_W-1:0]       r_lo;
    logic [CNT_W-1:0]          r_cnt;

    logic signed [CAP_W:0]     w_in_ext;
    logic signed [CAP_W:0]     w_diff;
    logic signed [CAP_W:0]     w_capsum;
    logic [CAP_W-1:0]          w_mag;
    logic [CAP_W:0]            w_add;
    logic [GAIN_W-1:0]         w_vol1;
    logic [GAIN_W-1:0]         w_gain;
    logic signed [OUT_W-1:0]   w_sat;

    function automatic logic signed [CAP_W-1:0] sat40(input logic signed [CAP_W:0] v);
        logic signed [CAP_W-1:0] r;
        if (v[CAP_W] != v[CAP_W-1]) begin
            r = v[CAP_W] ? {1'b1, {(CAP_W-1){1'b0}}} : {1'b0, {(CAP_W-1){1'b1}}};
        end else begin
            r = v[CAP_W-1:0];
        end
        return r;
    endfunction

    assign w_in_ext = {{(CAP_W+1-IN_W){r_in[IN_W-1]}}, r_in};
    assign w_diff   = w_in_ext - {r_cap[CAP_W-1], r_cap};
    assign w_capsum = r_neg ? (w_in_ext + $signed(r_hi)) : (w_in_ext - $signed(r_hi));
    assign w_mag    = r_out[CAP_W-1] ? $unsigned(-r_out) : $unsigned(r_out);
    assign w_add    = r_hi + {1'b0, (r_lo[0] ? r_mag : {CAP_W{1'b0}})};
    assign w_vol1   = GAIN_W'(i_ctrl.vol) + GAIN_W'(1);
    assign w_gain   = (w_vol1 << FULL_SCALE_LOG2) - w_vol1;

    // truncated magnitude back to signed 16 bits with saturation
    always_comb begin
        if (r_neg) begin
            if (r_hi > (CAP_W+1)'(OUT_NEG_MAX)) begin
                w_sat = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                w_sat = -$signed(r_hi[OUT_W-1:0]);
            end
        end else begin
            if (r_hi > (CAP_W+1)'(OUT_POS_MAX)) begin
                w_sat = {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                w_sat = $signed(r_hi[OUT_W-1:0]);
            end
        end
    end

    assign o_result    = w_sat;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctrl.start) begin
                        r_in    <= {i_sum, {IN_SHIFT{1'b0}}};
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_out   <= sat40(w_diff);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg   <= r_out[CAP_W-1];
                    r_mag   <= w_mag;
                    r_hi    <= '0;
                    r_lo    <= MUL_LO_W'(i_ctrl.coef);
                    r_cnt   <= CNT_W'(COEF_BITS - 1);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_hi  <= {1'b0, w_add[CAP_W:1]};
                    r_lo  <= {w_add[0], r_lo[MUL_LO_W-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_CAP;
                    end
                end
                S_CAP: begin
                    r_cap   <= sat40(w_capsum);
                    r_hi    <= '0;
                    r_lo    <= MUL_LO_W'(w_gain);
                    r_cnt   <= CNT_W'(SCALE_SHIFT - 1);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_hi  <= {1'b0, w_add[CAP_W:1]};
                    r_lo  <= {w_add[0], r_lo[MUL_LO_W-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/stereo_mixer_dc_high_pass_core.sv =====
// stereo mixer top level: apb registers, channel routing and result register
//
// input requests carry four 15-bit channel samples plus the enable and dac
// flags; i_valid / o_ready, taken at the edge where both are high.
// results carry left and right 16-bit samples on o_valid / i_ready.
// registers sit on the apb port at byte addresses 0, 4, 8, 12 and 16:
// power, panning mask, left volume, right volume, filter coefficient.
// with power on and any dac on, a request runs from acceptance to the result
// register through the two bit-serial multiply passes of each side's filter
// unit, first over the coefficient bits, then over the scaling bits;
// both sides run in parallel. otherwise the result is zero.
// one request is in work at a time; the next is taken as soon as the result
// has moved to the output register, even while that waits.
// a stalled receiver holds the result register and, once a second result
// is ready, holds the core until the first is taken.
// reset clears the registers to their defaults and both capacitors to 0.
`timescale 1ns / 1ps
`include "stereo_mixer_dc_high_pass_core_assert.svh"
module stereo_mixer_dc_high_pass_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [smx_pkg::SAMPLE_W-1:0]   i_ch1_sample,
    input  logic signed [smx_pkg::SAMPLE_W-1:0]   i_ch2_sample,
    input  logic signed [smx_pkg::SAMPLE_W-1:0]   i_ch3_sample,
    input  logic signed [smx_pkg::SAMPLE_W-1:0]   i_ch4_sample,
    input  logic [smx_pkg::CH_N-1:0]              i_channel_active,
    input  logic [smx_pkg::CH_N-1:0]              i_dac_on,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [smx_pkg::OUT_W-1:0]      o_left_out,
    output logic signed [smx_pkg::OUT_W-1:0]      o_right_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [4:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import smx_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        REG_POWER = 3'd0,
        REG_PAN   = 3'd1,
        REG_LVOL  = 3'd2,
        REG_RVOL  = 3'd3,
        REG_COEF  = 3'd4
    } t_reg_idx;

    t_state                   r_state;
    logic                     r_power;
    logic [MASK_W-1:0]        r_pan;
    logic [VOL_W-1:0]         r_lvol;
    logic [VOL_W-1:0]         r_rvol;
    logic [COEF_BITS-1:0]     r_coef;
    logic                     r_start;
    logic                     r_zero;
    logic signed [SUM_W-1:0]  r_lsum;
    logic signed [SUM_W-1:0]  r_rsum;
    logic                     r_o_valid;
    logic signed [OUT_W-1:0]  r_left;
    logic signed [OUT_W-1:0]  r_right;

    logic signed [SAMPLE_W-1:0] w_smp [CH_N];
    logic signed [SUM_W-1:0]    w_lsum;
    logic signed [SUM_W-1:0]    w_rsum;
    logic                       w_accept;
    logic                       w_wr;
    t_reg_idx                   w_idx;
    t_hpf_ctrl                  w_l_ctrl;
    t_hpf_ctrl                  w_r_ctrl;
    t_hpf_stat                  w_l_stat;
    t_hpf_stat                  w_r_stat;
    logic signed [OUT_W-1:0]    w_l_res;
    logic signed [OUT_W-1:0]    w_r_res;

    assign w_smp[0] = i_ch1_sample;
    assign w_smp[1] = i_ch2_sample;
    assign w_smp[2] = i_ch3_sample;
    assign w_smp[3] = i_ch4_sample;

    // routing: upper mask nibble feeds left, lower nibble feeds right
    always_comb begin
        w_lsum = '0;
        w_rsum = '0;
        for (int i = 0; i < CH_N; i++) begin
            if (i_channel_active[i] && r_pan[i+CH_N]) begin
                w_lsum = w_lsum + SUM_W'(w_smp[i]);
            end
            if (i_channel_active[i] && r_pan[i]) begin
                w_rsum = w_rsum + SUM_W'(w_smp[i]);
            end
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_o_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

    // apb register file
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_comb begin
        unique case (w_idx)
            REG_POWER: prdata = 32'(r_power);
            REG_PAN:   prdata = 32'(r_pan);
            REG_LVOL:  prdata = 32'(r_lvol);
            REG_RVOL:  prdata = 32'(r_rvol);
            REG_COEF:  prdata = 32'(r_coef);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= 1'b0;
            r_pan   <= '0;
            r_lvol  <= '0;
            r_rvol  <= '0;
            r_coef  <= COEF_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POWER: r_power <= pwdata[0];
                REG_PAN:   r_pan   <= pwdata[MASK_W-1:0];
                REG_LVOL:  r_lvol  <= pwdata[VOL_W-1:0];
                REG_RVOL:  r_rvol  <= pwdata[VOL_W-1:0];
                REG_COEF:  r_coef  <= pwdata[COEF_BITS-1:0];
                default:   ;
            endcase
        end
    end

    assign w_l_ctrl = '{start: r_start, coef: r_coef, vol: r_lvol};
    assign w_r_ctrl = '{start: r_start, coef: r_coef, vol: r_rvol};

    smx_hpf u_hpf_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_l_ctrl),
        .i_sum    (r_lsum),
        .o_stat   (w_l_stat),
        .o_result (w_l_res)
    );

    smx_hpf u_hpf_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_r_ctrl),
        .i_sum    (r_rsum),
        .o_stat   (w_r_stat),
        .o_result (w_r_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_o_valid && i_ready && (r_state != S_FLUSH)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_lsum <= w_lsum;
                        r_rsum <= w_rsum;
                        if (!r_power || (i_dac_on == '0)) begin
                            r_zero  <= 1'b1;
                            r_state <= S_FLUSH;
                        end else begin
                            r_zero  <= 1'b0;
                            r_start <= 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_l_stat.done) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_o_valid || i_ready) begin
                        r_left    <= r_zero ? '0 : w_l_res;
                        r_right   <= r_zero ? '0 : w_r_res;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SMX_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, w_accept, !o_ready)
    `SMX_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, r_start, !w_l_stat.busy && !w_r_stat.busy)
    `SMX_ASSERT_IMPL(a_done_pair, i_clk, i_rst_n, w_l_stat.done || w_r_stat.done, w_l_stat.done && w_r_stat.done)
    `SMX_ASSERT_IMPL(a_done_run, i_clk, i_rst_n, w_l_stat.done, r_state == S_RUN)

endmodule
